[design/ckh_pkg.sv]
// ----------------------------------------------------------------------------
// ckh_pkg
// Shared types and constants for the column key hash engine: function codes,
// hashing constants, the queued work item and the back end state type.
// ----------------------------------------------------------------------------
package ckh_pkg;

    localparam logic [63:0] MUL_A      = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MUL_B      = 64'h94d049bb133111eb;
    localparam logic [63:0] MIX_CONST  = 64'h09e3779b97f617db;
    localparam logic [63:0] ACCUM_INIT = 64'h0000000000000100;
    localparam logic [63:0] NEG_ZERO   = 64'h8000000000000000;
    localparam logic [7:0]  ACCUM_MUL  = 8'd131;

    localparam int unsigned SHIFT_1 = 30;
    localparam int unsigned SHIFT_2 = 27;
    localparam int unsigned SHIFT_3 = 31;
    localparam int unsigned SEED_SHL = 6;
    localparam int unsigned SEED_SHR = 2;

    typedef enum logic [1:0] {
        FN_INT     = 2'd0,
        FN_DOUBLE  = 2'd1,
        FN_STRING  = 2'd2,
        FN_COMBINE = 2'd3
    } t_func;

    // fin set: value goes through the finaliser, clear: value is the result
    typedef struct packed {
        logic        fin;
        logic [63:0] value;
    } t_work;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_MUL  = 2'd1,
        BK_OUT  = 2'd2
    } t_back_state;

    // multiply steps over 32-bit halves
    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HL = 2'd2;

endpackage

[design/ckh_front.sv]
// ----------------------------------------------------------------------------
// ckh_front
// Accepts input items, folds string bytes into the running value, maps
// negative zero, performs the seed combine, and queues work for the back end.
// ----------------------------------------------------------------------------
module ckh_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_full,
    input  logic [1:0]    i_func,
    input  logic [63:0]   i_key,
    input  logic [63:0]   i_seed_in,
    input  logic [7:0]    i_text_byte,
    input  logic          i_has_byte,
    input  logic          i_last,
    output logic          o_wr,
    output ckh_pkg::t_work o_work
);

    logic [63:0]   r_accum;
    logic [63:0]   n_accum;
    logic [63:0]   w_folded;
    logic [63:0]   w_combine;
    logic          w_accept;
    ckh_pkg::t_func w_func;

    assign w_accept = i_push && !i_full;
    assign w_func   = ckh_pkg::t_func'(i_func);
    assign w_folded = i_has_byte
        ? 64'(r_accum * {56'd0, ckh_pkg::ACCUM_MUL}) + {56'd0, i_text_byte}
        : r_accum;
    assign w_combine = i_seed_in ^ (i_key + ckh_pkg::MIX_CONST
                                    + (i_seed_in << ckh_pkg::SEED_SHL)
                                    + (i_seed_in >> ckh_pkg::SEED_SHR));

    always_comb begin
        n_accum      = r_accum;
        o_wr         = 1'b0;
        o_work.fin   = 1'b1;
        o_work.value = i_key;
        unique case (w_func)
            ckh_pkg::FN_INT: begin
                o_wr = w_accept;
            end
            ckh_pkg::FN_DOUBLE: begin
                o_wr = w_accept;
                if (i_key == ckh_pkg::NEG_ZERO) begin
                    o_work.value = '0;
                end
            end
            ckh_pkg::FN_STRING: begin
                o_work.value = w_folded;
                o_wr         = w_accept && i_last;
                if (w_accept) begin
                    n_accum = i_last ? ckh_pkg::ACCUM_INIT : w_folded;
                end
            end
            default: begin
                o_wr         = w_accept;
                o_work.fin   = 1'b0;
                o_work.value = w_combine;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= ckh_pkg::ACCUM_INIT;
        end else begin
            r_accum <= n_accum;
        end
    end

endmodule

[design/ckh_queue.sv]
// ----------------------------------------------------------------------------
// ckh_queue
// Short first-in first-out queue of work items between front and back end.
// ----------------------------------------------------------------------------
module ckh_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  ckh_pkg::t_work i_work,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output ckh_pkg::t_work o_work
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ckh_pkg::t_work r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           w_wr;
    logic           w_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_work  = r_mem[r_rd_ptr];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

endmodule

[design/ckh_back.sv]
// ----------------------------------------------------------------------------
// ckh_back
// Splitmix64 finaliser on one shared 32x32 multiplier, three partial
// products per 64-bit multiply, feeding a one-entry result register.
// ----------------------------------------------------------------------------
module ckh_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  ckh_pkg::t_work i_q_work,
    output logic           o_q_rd,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [63:0]    o_hash
);

    ckh_pkg::t_back_state r_state;
    ckh_pkg::t_back_state n_state;

    logic [63:0] r_z;
    logic [63:0] n_z;
    logic [63:0] r_acc;
    logic [1:0]  r_step;
    logic [1:0]  n_step;
    logic        r_pass;
    logic        n_pass;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [63:0] r_out_hash;

    logic [63:0] w_mul;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic [63:0] w_sum;
    logic        w_load_out;

    assign w_mul   = r_pass ? ckh_pkg::MUL_B : ckh_pkg::MUL_A;
    assign w_mul_a = (r_step == ckh_pkg::STEP_HL) ? r_z[63:32] : r_z[31:0];
    assign w_mul_b = (r_step == ckh_pkg::STEP_LH) ? w_mul[63:32] : w_mul[31:0];
    assign w_prod  = 64'(w_mul_a) * 64'(w_mul_b);
    assign w_sum   = (r_step == ckh_pkg::STEP_LL) ? w_prod
                                                  : r_acc + {w_prod[31:0], 32'd0};

    assign w_load_out = (r_state == ckh_pkg::BK_OUT) && (!r_out_valid || i_pop);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ckh_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_q_work.fin ? ckh_pkg::BK_MUL : ckh_pkg::BK_OUT;
                end
            end
            ckh_pkg::BK_MUL: begin
                if (r_step == ckh_pkg::STEP_HL && r_pass) begin
                    n_state = ckh_pkg::BK_OUT;
                end
            end
            ckh_pkg::BK_OUT: begin
                if (w_load_out) begin
                    n_state = ckh_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = ckh_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_q_rd = 1'b0;
        n_z    = r_z;
        n_step = r_step;
        n_pass = r_pass;
        unique case (r_state)
            ckh_pkg::BK_IDLE: begin
                o_q_rd = i_q_valid;
                n_step = ckh_pkg::STEP_LL;
                n_pass = 1'b0;
                n_z    = i_q_work.fin
                    ? i_q_work.value ^ (i_q_work.value >> ckh_pkg::SHIFT_1)
                    : i_q_work.value;
            end
            ckh_pkg::BK_MUL: begin
                n_step = r_step + 1'b1;
                if (r_step == ckh_pkg::STEP_HL) begin
                    n_step = ckh_pkg::STEP_LL;
                    n_pass = 1'b1;
                    n_z    = r_pass ? w_sum ^ (w_sum >> ckh_pkg::SHIFT_3)
                                    : w_sum ^ (w_sum >> ckh_pkg::SHIFT_2);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_hash  = r_out_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ckh_pkg::BK_IDLE;
            r_step      <= ckh_pkg::STEP_LL;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z   <= n_z;
        r_acc <= w_sum;
        if (w_load_out) begin
            r_out_hash <= r_z;
        end
    end

endmodule

[design/column_key_hash_engine.sv]
// ----------------------------------------------------------------------------
// column_key_hash_engine
// Hash engine for database keys: splitmix64 finaliser on integers, doubles
// and strings (one byte per transfer), plus a seed combine.
// ----------------------------------------------------------------------------
// flow: string bytes that give no result stall only on a full queue; the
//   back end takes one item at a time to the result register, a hashed
//   key through the shared 32x32 multiplier (three partial products per
//   64-bit multiply), while a combine skips the multiplier
// reset: synchronous, active low; empties queue and result register and
//   sets the string running value to 256
module column_key_hash_engine #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_key,
    input  logic [63:0] i_seed_in,
    input  logic [7:0]  i_text_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [63:0] o_hash
);

    logic           w_wr;
    ckh_pkg::t_work w_wr_work;
    logic           w_q_valid;
    logic           w_q_rd;
    ckh_pkg::t_work w_q_work;

    ckh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_full      (o_full),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_seed_in   (i_seed_in),
        .i_text_byte (i_text_byte),
        .i_has_byte  (i_has_byte),
        .i_last      (i_last),
        .o_wr        (w_wr),
        .o_work      (w_wr_work)
    );

    ckh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_work  (w_wr_work),
        .o_full  (o_full),
        .i_rd    (w_q_rd),
        .o_valid (w_q_valid),
        .o_work  (w_q_work)
    );

    ckh_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_work  (w_q_work),
        .o_q_rd    (w_q_rd),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_hash    (o_hash)
    );

endmodule

[design/ckh_checker.sv]
// ----------------------------------------------------------------------------
// ckh_checker
// Port level checks for the column key hash engine, bound to the top level.
// ----------------------------------------------------------------------------
module ckh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_full,
    input logic        o_empty,
    input logic        i_pop,
    input logic [63:0] o_hash
);

    // leaving reset with the queue not full and nothing to deliver
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (o_empty && !o_full))
        else $error("not empty or full on leaving reset");

    // no result can be ready in the cycle after leaving reset
    a_reset_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |=> o_empty)
        else $error("result appeared too early after reset");

    // with a queue of more than one entry, a single transfer into an idle engine cannot fill it
    a_no_early_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) ##1 !o_full |=> !o_full)
        else $error("queue full too soon after reset");

    // a waiting result holds until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_hash)))
        else $error("waiting result changed before transfer");

endmodule

bind column_key_hash_engine ckh_checker u_ckh_checker (.*);
